// File: src/pba_pkg.sv
package pba_pkg;

  // map geometry
  localparam int SLOTS   = 1024;
  localparam int IDX_W   = 10;
  localparam int WORD_W  = (SLOTS >= 32) ? 32 : (2 ** $clog2(SLOTS));
  localparam int BIT_W   = $clog2(WORD_W);
  localparam int WORDS   = (SLOTS + WORD_W - 1) / WORD_W;
  localparam int WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;

  // request codes
  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [IDX_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] given_slot;
    logic             slot_free;
    logic             map_full;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic capture;  // latch request, pick word
    logic read;     // registered read of the selected word
    logic commit;   // write back, load response register
  } cmd_t;

endpackage

// File: src/page_bitmap_allocator.sv
// channel  | valid      | ready      | payload | carries
// request  | req_valid  | req_ready  | req     | req_type, slot_index
// response | rsp_valid  | rsp_ready  | rsp     | given_slot, slot_free, map_full
//
// each transaction runs through capture, word read, and update with write back
// the single map memory port (one word read, one word write) keeps these steps apart
// a new request is taken while the previous response waits; it then holds in
// the update step until the response register is free
// reset clears the per-word valid and full bits at once, no clearing pass
module page_bitmap_allocator (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  pba_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output pba_pkg::rsp_t rsp
);
  import pba_pkg::*;

  cmd_t cmd;

  // sequencer: idle, read, update
  pba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd)
  );

  // map words, word summary, first-fit search and response register
  pba_datapath u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

  // a captured transaction blocks further requests until it is written back
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while a transaction is in flight");

  // a response appears only after a write-back step
  a_rsp_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(cmd.commit))
    else $error("response raised without a commit");

  // a full map grants nothing
  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.map_full |-> rsp.given_slot == '0 && !rsp.slot_free)
    else $error("full response carries a grant or query bit");

  // capture, read and commit never coincide
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.capture, cmd.read, cmd.commit}) <= 1)
    else $error("overlapping datapath commands");

endmodule

// File: src/pba_ctrl.sv
module pba_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output pba_pkg::cmd_t cmd
);
  import pba_pkg::*;

  state_t state, state_next;
  logic   rsp_valid_next;
  logic   rsp_room;

  // response register can take a new transaction
  assign rsp_room = !rsp_valid || rsp_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (req_valid) state_next = ST_READ;
      ST_READ:   state_next = ST_UPDATE;
      ST_UPDATE: if (rsp_room) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready   = (state == ST_IDLE);
    cmd.capture = (state == ST_IDLE) && req_valid;
    cmd.read    = (state == ST_READ);
    cmd.commit  = (state == ST_UPDATE) && rsp_room;
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (cmd.commit) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

// File: src/pba_datapath.sv
module pba_datapath (
  input  logic          clk,
  input  logic          rst,
  input  pba_pkg::cmd_t cmd,
  input  pba_pkg::req_t req,
  output pba_pkg::rsp_t rsp
);
  import pba_pkg::*;

  // map words; a word whose valid bit is clear reads as all free
  logic [WORD_W-1:0]  mem [WORDS];
  logic [WORDS-1:0]   word_valid;
  logic [WORDS-1:0]   word_full;

  // captured request
  logic [1:0]         req_type_q;
  logic [WADDR_W-1:0] waddr;
  logic [BIT_W-1:0]   bitpos;
  logic               in_range;
  logic               alloc_full;

  // read stage
  logic [WORD_W-1:0]  rd_word;
  logic               rd_valid;

  // search at capture
  logic [WADDR_W-1:0] free_waddr;
  logic               all_full;

  // update stage
  logic [WORD_W-1:0]  cur_word;
  logic [WORD_W-1:0]  pad_used;
  logic [WORD_W-1:0]  view;
  logic [BIT_W-1:0]   apos;
  logic [WORD_W-1:0]  new_word;
  logic               new_full;
  logic               wr_en;
  rsp_t               rsp_next;

  // lowest word that still has a free slot
  always_comb begin
    free_waddr = '0;
    for (int i = WORDS - 1; i >= 0; i--) begin
      if (!word_full[i]) free_waddr = WADDR_W'(i);
    end
    all_full = &word_full;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_type_q <= req.req_type;
      in_range   <= (32'(req.slot_index) < 32'(SLOTS));
      alloc_full <= all_full;
      if (req.req_type == REQ_ALLOC) begin
        waddr  <= free_waddr;
        bitpos <= '0;
      end else begin
        waddr  <= WADDR_W'(req.slot_index >> BIT_W);
        bitpos <= req.slot_index[BIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_word  <= mem[waddr];
      rd_valid <= word_valid[waddr];
    end
  end

  // bits past the end of the map count as used
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      pad_used[b] = ((int'(waddr) * WORD_W + b) >= SLOTS);
    end
  end

  always_comb begin
    cur_word = rd_valid ? rd_word : '0;
    view     = cur_word | pad_used;
    apos     = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (!view[b]) apos = BIT_W'(b);
    end
  end

  always_comb begin
    new_word = cur_word;
    new_full = 1'b0;
    wr_en    = 1'b0;
    rsp_next = '0;
    case (req_type_q)
      REQ_ALLOC: begin
        if (alloc_full) begin
          rsp_next.map_full = 1'b1;
        end else begin
          new_word            = cur_word | (WORD_W'(1) << apos);
          new_full            = &(new_word | pad_used);
          wr_en               = 1'b1;
          rsp_next.given_slot = IDX_W'({waddr, apos});
        end
      end
      REQ_FREE: begin
        new_word = cur_word & ~(WORD_W'(1) << bitpos);
        wr_en    = in_range;
      end
      REQ_QUERY: begin
        rsp_next.slot_free = in_range && !cur_word[bitpos];
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      mem[waddr] <= new_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
      word_full  <= '0;
    end else if (cmd.commit && wr_en) begin
      word_valid[waddr] <= 1'b1;
      word_full[waddr]  <= new_full;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp <= rsp_next;
    end
  end

endmodule
